[src/masked_byte_pattern_search_core_assert.svh]
// Assertion macros shared by the masked byte pattern search modules.
`ifndef MASKED_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MBPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("masked byte pattern search: assertion failed");
`define MBPS_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("masked byte pattern search: assertion failed");
`else
`define MBPS_ASSERT(lbl, prop)
`define MBPS_ASSERT_NR(lbl, prop)
`endif
`endif

[src/mbps_pkg.sv]
// Types and constants shared by the masked byte pattern search modules.
package mbps_pkg;

  localparam int unsigned MAX_BYTES = 16;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned LEN_BITS = 5;
  localparam int unsigned RES_OFFSET_BITS = 32;

  localparam logic [15:0] CARE_MASK_RESET = 16'hFFFF;
  localparam logic [LEN_BITS-1:0] PATTERN_LENGTH_RESET = 5'd16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_CARE_MASK      = 2'd2,
    REG_PATTERN_LENGTH = 2'd3
  } reg_idx_e;

  // Pattern and care bits aligned by distance from the newest byte.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] pat;
    logic [MAX_BYTES-1:0]      care;
    logic [LEN_BITS-1:0]       len;
  } cfg_t;

  typedef struct packed {
    logic                       found;
    logic [RES_OFFSET_BITS-1:0] match_offset;
  } res_t;

endpackage

[src/mbps_cfg.sv]
// Configuration registers and distance alignment of the pattern and care mask.
module mbps_cfg #(
  parameter int unsigned PATTERN_BYTES = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  input  logic [mbps_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  output mbps_pkg::cfg_t                          cfg_o
);

  localparam int unsigned MB = mbps_pkg::MAX_BYTES;
  localparam int unsigned LB = mbps_pkg::LEN_BITS;

  logic [63:0]   pat_lo_q, pat_hi_q;
  logic [15:0]   care_q;
  logic [LB-1:0] plen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= mbps_pkg::CARE_MASK_RESET;
      plen_q   <= mbps_pkg::PATTERN_LENGTH_RESET;
    end else if (cfg_valid_i) begin
      unique case (mbps_pkg::reg_idx_e'(cfg_index_i))
        mbps_pkg::REG_PATTERN_LOW:    pat_lo_q <= cfg_data_i;
        mbps_pkg::REG_PATTERN_HIGH:   pat_hi_q <= cfg_data_i;
        mbps_pkg::REG_CARE_MASK:      care_q   <= cfg_data_i[15:0];
        mbps_pkg::REG_PATTERN_LENGTH: plen_q   <= cfg_data_i[LB-1:0];
        default: ;
      endcase
    end
  end

  logic [MB-1:0][7:0] pbytes, rev_pat;
  logic [MB-1:0]      rev_care;
  logic [LB-1:0]      len_eff;
  logic [LB-1:0]      shift_amt;

  always_comb begin
    pbytes = {pat_hi_q, pat_lo_q};
    if (plen_q == '0) begin
      len_eff = LB'(1);
    end else if (plen_q > LB'(PATTERN_BYTES)) begin
      len_eff = LB'(PATTERN_BYTES);
    end else begin
      len_eff = plen_q;
    end
    for (int k = 0; k < MB; k++) begin
      if (k < PATTERN_BYTES) begin
        rev_pat[k]  = pbytes[PATTERN_BYTES-1-k];
        rev_care[k] = care_q[PATTERN_BYTES-1-k];
      end else begin
        rev_pat[k]  = '0;
        rev_care[k] = 1'b0;
      end
    end
    shift_amt    = LB'(PATTERN_BYTES) - len_eff;
    cfg_o.pat    = rev_pat >> {shift_amt, 3'b000};
    cfg_o.care   = rev_care >> shift_amt;
    cfg_o.len    = len_eff;
  end

endmodule

[src/mbps_scan.sv]
// Byte history, region counter and masked window compare.
`include "masked_byte_pattern_search_core_assert.svh"
module mbps_scan #(
  parameter int unsigned PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS   = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     data_i,
  input  logic           last_i,
  input  mbps_pkg::cfg_t cfg_i,
  output logic           res_valid_o,
  output mbps_pkg::res_t res_o
);

  localparam int unsigned WIN_DEPTH = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1;
  localparam int unsigned LB = mbps_pkg::LEN_BITS;

  logic [WIN_DEPTH-1:0][7:0]     win_q, win_d;
  logic [OFFSET_BITS-1:0]        cnt_q, cnt_d;
  logic                          rep_q, rep_d;
  logic [PATTERN_BYTES-1:0][7:0] hist;
  logic                          match, pos_ok, found_now;
  logic [LB-1:0]                 len_m1;
  logic [OFFSET_BITS-1:0]        diff;

  always_comb begin
    hist[0] = data_i;
    for (int d = 1; d < PATTERN_BYTES; d++) begin
      hist[d] = win_q[d-1];
    end
    match = 1'b1;
    for (int d = 0; d < PATTERN_BYTES; d++) begin
      if (cfg_i.care[d] && (hist[d] != cfg_i.pat[d])) begin
        match = 1'b0;
      end
    end
    len_m1    = cfg_i.len - LB'(1);
    pos_ok    = cnt_q >= OFFSET_BITS'(len_m1);
    diff      = cnt_q - OFFSET_BITS'(len_m1);
    found_now = !rep_q && pos_ok && match;

    res_valid_o        = accept_i && (found_now || (last_i && !rep_q));
    res_o.found        = found_now;
    res_o.match_offset = found_now ? mbps_pkg::RES_OFFSET_BITS'(diff) : '0;

    win_d = win_q;
    cnt_d = cnt_q;
    rep_d = rep_q;
    if (accept_i) begin
      if (last_i) begin
        cnt_d = '0;
        rep_d = 1'b0;
      end else begin
        for (int k = WIN_DEPTH - 1; k > 0; k--) begin
          win_d[k] = win_q[k-1];
        end
        win_d[0] = data_i;
        if (cnt_q != {OFFSET_BITS{1'b1}}) begin
          cnt_d = cnt_q + OFFSET_BITS'(1);
        end
        rep_d = rep_q | found_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rep_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rep_q <= rep_d;
    end
  end

  `MBPS_ASSERT(a_last_clears, accept_i && last_i |=> (cnt_q == '0) && !rep_q)
  `MBPS_ASSERT(a_one_result, rep_q |-> !res_valid_o)
  `MBPS_ASSERT(a_found_marks, accept_i && found_now && !last_i |=> rep_q)

endmodule

[src/masked_byte_pattern_search_core.sv]
// Top level of the masked byte pattern search with its output register.
//
// The input stream carries one byte per beat in s_axis_tdata_i, with
// s_axis_tlast_i marking the final byte of a region. The block keeps the
// most recent bytes and compares them in parallel with the configured
// pattern under the care mask, so one byte is taken per cycle unless stalled.
// At the first match one result beat leaves on the output stream with
// m_axis_tuser_o set and the start offset in m_axis_tdata_o; a region that
// ends without a match gives one beat with both cleared. After the final
// byte the scan state clears for the next region.
// A result appears on the output in the cycle after the byte that causes it
// is accepted; throughput is one byte per cycle unless stalled, set by the
// combinational window compare between history and output registers.
// When the receiver stalls, the result waits in the output register and
// the input is held off until that beat has been taken.
// Reset clears the scan state, empties the output register and restores
// the register defaults. Configuration writes on the cfg channel are
// always accepted and are meant for times when the block is idle.
`include "masked_byte_pattern_search_core_assert.svh"
module masked_byte_pattern_search_core #(
  parameter int unsigned PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] match_offset
  output logic [0:0]  m_axis_tuser_o,   // [0] found
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [mbps_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  mbps_pkg::cfg_t cfg;
  mbps_pkg::res_t res, out_q, out_d;
  logic           res_valid;
  logic           out_valid_q, out_valid_d;
  logic           accept;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  mbps_cfg #(
    .PATTERN_BYTES(PATTERN_BYTES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mbps_scan #(
    .PATTERN_BYTES(PATTERN_BYTES),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_i     (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .cfg_i      (cfg),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_q.match_offset;
  assign m_axis_tuser_o[0] = out_q.found;

  `MBPS_ASSERT(a_full_blocks_input, out_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
  `MBPS_ASSERT(a_miss_zero_offset, out_valid_q && !out_q.found |-> out_q.match_offset == '0)
  `MBPS_ASSERT(a_taken_empties, out_valid_q && m_axis_tready_i && !res_valid |=> !out_valid_q)
  `MBPS_ASSERT_NR(a_reset_empty, !rst_ni |-> !m_axis_tvalid_o)

endmodule

[verif/tb_masked_byte_pattern_search_core.sv]
// Self-checking testbench for the masked byte pattern search core.
module tb_masked_byte_pattern_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned BYTES_PER_PHASE = 100;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    mbps_pkg::reg_idx_e idx;
    logic [63:0]        value;
    logic [7:0]         data;
    logic               is_last;
    logic               typed;
    logic               has;
    mbps_pkg::res_t     want;
  } stim_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  mbps_pkg::reg_idx_e cfg_index_i = mbps_pkg::REG_PATTERN_LOW;
  logic [63:0] cfg_data_i      = '0;

  // Typed expectation travelling alongside the input beat.
  logic           row_typed = 1'b0;
  logic           row_has   = 1'b0;
  mbps_pkg::res_t row_res   = '0;

  // Scan predictor: register copy and history.
  logic [63:0]                   pat_lo_q   = '0;
  logic [63:0]                   pat_hi_q   = '0;
  logic [15:0]                   care_q     = mbps_pkg::CARE_MASK_RESET;
  logic [mbps_pkg::LEN_BITS-1:0] len_q      = mbps_pkg::PATTERN_LENGTH_RESET;
  logic [7:0]                    history_q [mbps_pkg::MAX_BYTES];
  logic [31:0]                   seen_q     = '0;
  logic                          reported_q = 1'b0;
  mbps_pkg::res_t                pending_results [$];

  stim_row_t   directed_rows [$];
  int unsigned src_pct     = 0;
  int unsigned snk_pct     = 0;
  int unsigned hold_id     = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned mismatches  = 0;
  int unsigned bytes_taken = 0;
  int unsigned regions     = 0;
  int unsigned found_beats = 0;
  int unsigned miss_beats  = 0;
  int unsigned reg_writes  = 0;

  masked_byte_pattern_search_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned active_length();
    if (len_q < 1) return 1;
    if (len_q > mbps_pkg::MAX_BYTES) return mbps_pkg::MAX_BYTES;
    return int'(len_q);
  endfunction

  function automatic logic [7:0] pattern_byte_at(int unsigned j);
    if (j < 8) return pat_lo_q[8*j +: 8];
    return pat_hi_q[8*(j-8) +: 8];
  endfunction

  function automatic logic window_hits(logic [7:0] cur, int unsigned n);
    int unsigned back;
    logic [7:0]  b;
    for (int unsigned j = 0; j < n; j++) begin
      back = n - 1 - j;
      if (!care_q[j]) continue;
      b = (back == 0) ? cur : history_q[back-1];
      if (b != pattern_byte_at(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_scan();
    foreach (history_q[k]) history_q[k] = '0;
    seen_q     = '0;
    reported_q = 1'b0;
  endfunction

  function automatic logic scan_byte(input logic [7:0] cur, input logic is_last,
                                     output mbps_pkg::res_t res);
    int unsigned n;
    logic        produced;
    n        = active_length();
    produced = 1'b0;
    res      = '0;
    if (!reported_q && seen_q >= n - 1 && window_hits(cur, n)) begin
      res.found        = 1'b1;
      res.match_offset = seen_q - 32'(n - 1);
      reported_q       = 1'b1;
      produced         = 1'b1;
    end else if (is_last && !reported_q) begin
      produced = 1'b1;
    end
    if (is_last) begin
      clear_scan();
    end else begin
      for (int k = mbps_pkg::MAX_BYTES - 1; k > 0; k--) history_q[k] = history_q[k-1];
      history_q[0] = cur;
      if (seen_q != '1) seen_q = seen_q + 1;
    end
    return produced;
  endfunction

  task automatic note_mismatch(input string what, input mbps_pkg::res_t want,
                               input mbps_pkg::res_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected found=%0b offset=%0d, got found=%0b offset=%0d",
               $realtime, what, want.found, want.match_offset, got.found, got.match_offset);
  endtask

  function automatic void add_reg_row(mbps_pkg::reg_idx_e idx, logic [63:0] value);
    stim_row_t r;
    r.kind    = ROW_REG;
    r.idx     = idx;
    r.value   = value;
    r.data    = '0;
    r.is_last = 1'b0;
    r.typed   = 1'b0;
    r.has     = 1'b0;
    r.want    = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_byte_row(logic [7:0] data, logic is_last, logic typed,
                                       logic has, logic found, logic [31:0] offset);
    stim_row_t r;
    r.kind               = ROW_BYTE;
    r.idx                = mbps_pkg::REG_PATTERN_LOW;
    r.value              = '0;
    r.data               = data;
    r.is_last            = is_last;
    r.typed              = typed;
    r.has                = has;
    r.want.found         = found;
    r.want.match_offset  = offset;
    directed_rows.push_back(r);
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic is_last, input logic typed,
                           input logic has, input mbps_pkg::res_t want);
    while (src_pct != 0 && $urandom_range(99) < src_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tlast_i  <= is_last;
    row_typed       <= typed;
    row_has         <= has;
    row_res         <= want;
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input mbps_pkg::reg_idx_e idx, input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    case (idx)
      mbps_pkg::REG_PATTERN_LOW:    pat_lo_q = value;
      mbps_pkg::REG_PATTERN_HIGH:   pat_hi_q = value;
      mbps_pkg::REG_CARE_MASK:      care_q   = value[15:0];
      mbps_pkg::REG_PATTERN_LENGTH: len_q    = value[mbps_pkg::LEN_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : sink
    if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else if (hold_id != hold_seen) begin
      hold_seen = hold_id;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= snk_pct);
    end
  end

  always @(negedge clk_i) begin : scoreboard
    mbps_pkg::res_t predicted;
    mbps_pkg::res_t got;
    mbps_pkg::res_t want;
    logic           produced;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.found        = m_axis_tuser_o[0];
        got.match_offset = m_axis_tdata_o;
        if (got.found) found_beats++;
        else miss_beats++;
        if (pending_results.size() == 0) begin
          note_mismatch("result beat with nothing expected", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.found !== want.found || got.match_offset !== want.match_offset)
            note_mismatch("result beat differs", want, got);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        produced = scan_byte(s_axis_tdata_i, s_axis_tlast_i, predicted);
        if (row_typed) begin
          produced  = row_has;
          predicted = row_res;
        end
        if (produced) pending_results.push_back(predicted);
        bytes_taken++;
        if (s_axis_tlast_i) regions++;
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned len_cfg;
    int unsigned n;
    int unsigned rlen;
    int unsigned at;
    int unsigned sent_in_phase;
    int unsigned pick;
    logic [15:0] care_cfg;
    logic [63:0] lo_cfg;
    logic [63:0] hi_cfg;
    logic        in_reg_rows;
    logic        narrow;
    logic        plant;
    logic        drained;
    logic [7:0]  region_q [$];

    clear_scan();

    for (int i = 0; i < 15; i++) add_byte_row(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
    add_byte_row(8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0);
    add_byte_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0);
    add_reg_row(mbps_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
    add_reg_row(mbps_pkg::REG_CARE_MASK,      64'hFFFF_FFFF_FFFF_0000);
    add_byte_row(8'h5A, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0);
    add_byte_row(8'h5A, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
    add_byte_row(8'h5A, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0);
    add_reg_row(mbps_pkg::REG_PATTERN_LOW,    64'h0123_4567_89AB_80FF);
    add_reg_row(mbps_pkg::REG_PATTERN_HIGH,   64'hFFFF_FFFF_FFFF_FFFF);
    add_reg_row(mbps_pkg::REG_CARE_MASK,      64'h0000_0000_0000_FFFF);
    add_reg_row(mbps_pkg::REG_PATTERN_LENGTH, 64'd2);
    add_byte_row(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
    add_byte_row(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
    add_byte_row(8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
    add_byte_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_reg_rows = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        if (!in_reg_rows) wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
        in_reg_rows = 1'b1;
      end else begin
        if (in_reg_rows) cfg_valid_i <= 1'b0;
        in_reg_rows = 1'b0;
        send_byte(directed_rows[i].data, directed_rows[i].is_last, directed_rows[i].typed,
                  directed_rows[i].has, directed_rows[i].want);
      end
    end

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       len_cfg = 31;
        1:       len_cfg = 0;
        2:       len_cfg = 1;
        3:       len_cfg = 16;
        4:       len_cfg = 17;
        default: len_cfg = $urandom_range(31);
      endcase
      if (phase == 1) care_cfg = 16'h0000;
      else if (phase % 3 == 0) care_cfg = 16'hFFFF;
      else care_cfg = 16'($urandom_range(16'hFFFF));
      if (phase == 3) begin
        lo_cfg = '0;
        hi_cfg = '0;
      end else if (phase == 4) begin
        lo_cfg = '1;
        hi_cfg = '1;
      end else begin
        lo_cfg = {$urandom, $urandom};
        hi_cfg = {$urandom, $urandom};
      end

      wait_idle();
      write_reg(mbps_pkg::REG_PATTERN_LOW, lo_cfg);
      write_reg(mbps_pkg::REG_PATTERN_HIGH, hi_cfg);
      write_reg(mbps_pkg::REG_CARE_MASK, {$urandom, 16'($urandom), care_cfg});
      write_reg(mbps_pkg::REG_PATTERN_LENGTH, {$urandom, 27'($urandom), 5'(len_cfg)});
      cfg_valid_i <= 1'b0;

      // The receiver holds off while short matching regions keep arriving.
      if (phase == 2) begin
        src_pct = 0;
        snk_pct <= 0;
        hold_id <= hold_id + 1;
      end

      n             = active_length();
      sent_in_phase = 0;
      drained       = 1'b0;
      while (sent_in_phase < BYTES_PER_PHASE) begin
        if (phase != 2) begin
          pick = $urandom_range(5);
          src_pct = (pick == 3) ? 83 : (pick == 5) ? 6 : 0;
          snk_pct <= (pick == 4) ? 83 : (pick == 5) ? 6 : 0;
        end
        if (phase == 2) rlen = $urandom_range(n + 3, n);
        else if ($urandom_range(9) < 2) rlen = $urandom_range(n, 1);
        else rlen = $urandom_range(n + 30, n);

        narrow = $urandom_range(1);
        region_q.delete();
        for (int unsigned i = 0; i < rlen; i++) begin
          if (narrow && $urandom_range(7) != 0)
            region_q.push_back(pattern_byte_at($urandom_range(n - 1)));
          else
            region_q.push_back(8'($urandom_range(255)));
        end

        plant = (phase == 2) || ($urandom_range(9) < 7);
        if (plant && rlen >= n) begin
          at = ($urandom_range(3) == 0) ? rlen - n : $urandom_range(rlen - n);
          for (int unsigned j = 0; j < n; j++)
            if (care_q[j]) region_q[at + j] = pattern_byte_at(j);
        end

        foreach (region_q[i])
          send_byte(region_q[i], i == region_q.size() - 1, 1'b0, 1'b0, '0);
        sent_in_phase += rlen;

        if (phase == 5 && !drained && sent_in_phase >= BYTES_PER_PHASE / 2) begin
          wait_idle();
          drained = 1'b1;
        end
      end
    end

    wait_idle();
    $display("Scanned %0d bytes in %0d regions across %0d register writes.",
             bytes_taken, regions, reg_writes);
    $display("Checked %0d found and %0d not-found result beats, %0d mismatches.",
             found_beats, miss_beats, mismatches);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
